FILE: hw/rtl/cpr_frame_deframe_decode_assert.svh
// Assertion macros for the frame deframer and decoder.
`ifndef CPR_FRAME_DEFRAME_DECODE_ASSERT_SVH
`define CPR_FRAME_DEFRAME_DECODE_ASSERT_SVH
`ifndef SYNTHESIS
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: hw/rtl/cfd_pkg.sv
// Package: frame codes, record kinds, sequencer states and the record decoder.
`timescale 1ns / 1ps
package cfd_pkg;

	localparam logic [7:0] HEAD_BYTE  = 8'hFF;
	localparam logic [7:0] END_BYTE   = 8'hFC;
	localparam logic [7:0] T_PHASE    = 8'h91;
	localparam logic [7:0] T_SIX      = 8'h00;
	localparam logic [7:0] T_DEPTH    = 8'h2A;
	localparam logic [7:0] T_PRATE    = 8'h2B;
	localparam logic [7:0] T_VOLUME   = 8'h4A;
	localparam logic [7:0] T_BRATE    = 8'h4B;
	localparam logic [7:0] T_PSAMPLE  = 8'h21;
	localparam logic [7:0] T_BSAMPLE  = 8'h41;
	localparam logic [7:0] PRESS_MARK = 8'h1A;
	localparam logic [7:0] SIX_MASK   = 8'h3F;
	localparam logic [7:0] REL_MASK   = 8'h10;

	localparam logic [2:0] QUEUE_DEPTH = 3'd7;
	localparam logic [2:0] MIN_FRAME   = 3'd4;
	localparam logic [2:0] LEN_NONE    = 3'd0;
	localparam logic [2:0] LEN_4       = 3'd4;
	localparam logic [2:0] LEN_5       = 3'd5;
	localparam logic [2:0] LEN_6       = 3'd6;
	localparam logic [2:0] LEN_7       = 3'd7;

	localparam logic [3:0] K_OTHER   = 4'd0;
	localparam logic [3:0] K_PPHASE  = 4'd1;
	localparam logic [3:0] K_BPHASE  = 4'd2;
	localparam logic [3:0] K_DEPTH   = 4'd3;
	localparam logic [3:0] K_VOLUME  = 4'd4;
	localparam logic [3:0] K_PRATE   = 4'd5;
	localparam logic [3:0] K_BRATE   = 4'd6;
	localparam logic [3:0] K_PSAMPLE = 4'd7;
	localparam logic [3:0] K_BSAMPLE = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [2:0]  len;
		logic [7:0]  ftype;
		logic        active;
		logic [7:0]  depth;
		logic        rel_err;
		logic [3:0]  hand;
		logic [5:0]  volume;
		logic        stomach;
		logic [10:0] rate;
		logic [7:0]  resp;
		logic [15:0] ts;
	} rec_t;

	function automatic logic [2:0] type_len(input logic [7:0] t);
		logic [2:0] l;
		l = LEN_NONE;
		if (t == T_PHASE) l = LEN_5;
		else if (t == T_SIX) l = LEN_6;
		else if (t == T_DEPTH || t == T_PRATE || t == T_VOLUME || t == T_BRATE) l = LEN_7;
		return l;
	endfunction

	function automatic logic [7:0] bcd2(input logic [7:0] b);
		logic [7:0] hi10;
		hi10 = {4'd0, b[7:4]} * 8'd10;
		return hi10 + {4'd0, b[3:0]};
	endfunction

	function automatic rec_t decode(input logic [7:0] t, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
			input logic [2:0] len);
		rec_t r;
		logic [15:0] ts;
		logic [10:0] hund;
		r = '0;
		ts = (len == LEN_7) ? {b5, b4} : 16'd0;
		hund = {7'd0, b2[3:0]} * 11'd100;
		r.len = len;
		r.ftype = t;
		if (t == T_PHASE && len == LEN_5) begin
			r.kind = (b2 == PRESS_MARK) ? K_PPHASE : K_BPHASE;
			r.active = (b3 != 8'd0);
		end else if (t == T_DEPTH && len == LEN_7) begin
			r.kind = K_DEPTH;
			r.depth = b2;
			r.rel_err = |(b3 & REL_MASK);
			r.hand = b3[3:0];
			r.ts = ts;
		end else if (t == T_VOLUME && len == LEN_7) begin
			r.kind = K_VOLUME;
			r.volume = b2[5:0];
			r.stomach = b3[7];
			r.ts = ts;
		end else if (t == T_PRATE && len == LEN_7) begin
			r.kind = K_PRATE;
			r.rate = hund + {3'd0, bcd2(b3)};
			r.ts = ts;
		end else if (t == T_BRATE && len == LEN_7) begin
			r.kind = K_BRATE;
			r.rate = {3'd0, bcd2(b2)};
			r.resp = bcd2(b3);
			r.ts = ts;
		end else if (t == T_PSAMPLE || t == T_BSAMPLE) begin
			r.kind = (t == T_PSAMPLE) ? K_PSAMPLE : K_BSAMPLE;
			r.depth = b2 & SIX_MASK;
			r.ts = {15'd0, b2[6]};
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/cpr_frame_deframe_decode.sv
// Top level: byte queue, frame scan sequencer and decoded record output register.
`timescale 1ns / 1ps
`include "cpr_frame_deframe_decode_assert.svh"
//
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   rx_byte (one serial byte per word)
// output    out        out_valid / out_stall record_kind .. timestamp_or_rising
//
// A byte is taken only while the sequencer idles; it is appended to the
// seven-entry queue and the scan runs one queue check per cycle on the shared
// compare unit: drop a head byte, wait for more bytes, or emit a record.
// Each accepted byte starts a scan of head drops that ends in a wait or an emit.
// An emit waits while the output register still holds an untaken record.
// Reset empties the queue count and the output; queue contents stay undefined.
module cpr_frame_deframe_decode (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  record_kind,
	output logic [2:0]  frame_length,
	output logic [7:0]  frame_type,
	output logic        phase_active,
	output logic [7:0]  depth_value,
	output logic        release_error,
	output logic [3:0]  hand_position,
	output logic [5:0]  breath_volume,
	output logic        stomach_flag,
	output logic [10:0] rate_value,
	output logic [7:0]  resp_time,
	output logic [15:0] timestamp_or_rising
);
	import cfd_pkg::*;

	state_t      state_q;
	logic [7:0]  pb_q [7];
	logic [2:0]  cnt_q;
	logic        ov_q;
	rec_t        rec_q;

	logic        in_acc;
	logic        out_free;
	logic [2:0]  tlen;
	logic [7:0]  end_b;
	logic        act_idle;
	logic        act_drop;
	logic        act_emit;
	logic        emit_go;
	logic [2:0]  emit_len;
	rec_t        rec_d;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !(ov_q && out_stall);

	// Shared compare unit: one decision on the queue head per cycle.
	always_comb begin
		tlen = type_len(pb_q[1]);
		case (tlen)
			LEN_5:   end_b = pb_q[4];
			LEN_6:   end_b = pb_q[5];
			LEN_7:   end_b = pb_q[6];
			default: end_b = pb_q[3];
		endcase
		act_idle = 1'b0;
		act_drop = 1'b0;
		act_emit = 1'b0;
		emit_len = LEN_4;
		if (cnt_q < MIN_FRAME) begin
			act_idle = 1'b1;
		end else if (pb_q[0] != HEAD_BYTE) begin
			act_drop = 1'b1;
		end else if (pb_q[3] == END_BYTE) begin
			act_emit = 1'b1;
		end else if (tlen == LEN_NONE) begin
			act_drop = 1'b1;
		end else if (cnt_q < tlen) begin
			act_idle = 1'b1;
		end else if (end_b != END_BYTE) begin
			act_drop = 1'b1;
		end else begin
			act_emit = 1'b1;
			emit_len = tlen;
		end
	end

	assign rec_d = decode(pb_q[1], pb_q[2], pb_q[3], pb_q[4], pb_q[5], emit_len);

	// A record leaves the scan into the output register this cycle.
	assign emit_go = (state_q == ST_SCAN) && !act_idle && !act_drop && act_emit && out_free;

	// Sequencer, queue count and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 3'd0;
			ov_q    <= 1'b0;
		end else begin
			if (emit_go) ov_q <= 1'b1;
			else if (ov_q && !out_stall) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q   <= cnt_q + 3'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (act_idle) begin
						state_q <= ST_IDLE;
					end else if (act_drop) begin
						cnt_q <= cnt_q - 3'd1;
					end else if (act_emit && out_free) begin
						cnt_q   <= cnt_q - emit_len;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Queue storage and output payload; append, drop one, or drop a frame.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pb_q[cnt_q] <= rx_byte;
		end
		if (state_q == ST_SCAN) begin
			if (act_drop) begin
				for (int i = 0; i < 6; i++) pb_q[i] <= pb_q[i + 1];
			end else if (act_emit && out_free) begin
				rec_q <= rec_d;
				case (emit_len)
					LEN_4:   for (int i = 0; i < 3; i++) pb_q[i] <= pb_q[i + 4];
					LEN_5:   for (int i = 0; i < 2; i++) pb_q[i] <= pb_q[i + 5];
					LEN_6:   pb_q[0] <= pb_q[6];
					default: ;
				endcase
			end
		end
	end

	assign out_valid           = ov_q;
	assign record_kind         = rec_q.kind;
	assign frame_length        = rec_q.len;
	assign frame_type          = rec_q.ftype;
	assign phase_active        = rec_q.active;
	assign depth_value         = rec_q.depth;
	assign release_error       = rec_q.rel_err;
	assign hand_position       = rec_q.hand;
	assign breath_volume       = rec_q.volume;
	assign stomach_flag        = rec_q.stomach;
	assign rate_value          = rec_q.rate;
	assign resp_time           = rec_q.resp;
	assign timestamp_or_rising = rec_q.ts;

	`CFD_ASSERT(a_idle_room, clk, arst_n, (state_q == ST_IDLE) |-> (cnt_q < QUEUE_DEPTH), "queue full while idle")
	`CFD_ASSERT(a_acc_scan, clk, arst_n, in_acc |=> (state_q == ST_SCAN), "accepted word did not start a scan")
	`CFD_ASSERT(a_emit_src, clk, arst_n, $rose(ov_q) |-> $past(state_q == ST_SCAN), "record appeared outside a scan")
	`CFD_ASSERT(a_emit_len, clk, arst_n, $rose(ov_q) |-> (rec_q.len >= MIN_FRAME), "record with short frame length")
	`CFD_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> (state_q == ST_IDLE && !ov_q), "reset not idle")

endmodule
